### src/hbt_pkg.sv
// Shared constants and codes for the 2D Walsh-Hadamard block transform.
// No dependencies; imported by the top level.
package hbt_pkg;

	localparam int MAX_SIDE    = 8;
	localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int DATA_W      = 16;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int LOG_W       = 2;
	localparam int STAGE_W     = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCK_SIZE_LOG2 = 1'b0,
		CFG_INVERSE_MODE    = 1'b1
	} cfg_reg_t;

endpackage

### src/hbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hbt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/hadamard2d_block_transform.sv
// Top level of the 2D Walsh-Hadamard block transform.
// Depends on hbt_pkg and hbt_ram (two copies of the block store).
//
// Usage:
//   Samples of a square block (side S = 2^block_size_log2, area A = S*S)
//   transfer one per cycle on start/sample while busy is low, in raster order.
//   After the last sample busy rises and the block runs 2*L butterfly passes
//   (L = block_size_log2) over the store, one pair after another, since the
//   store has one write port: each pair writes its sum, then its difference.
//   Coefficients then appear on coefficient/last, one per cycle, marked by
//   result_valid for one cycle each; the first appears after the last pass
//   and the rest follow back to back.
//   busy falls in the cycle that shows the last coefficient.
//   Configuration writes on cfg_wr_en/cfg_index/cfg_data take effect at once;
//   writing block_size_log2 drops a partial block.
//   Reset clears the fill count and sets side 4, forward mode.
//   The receiver cannot stall: results must be taken as they appear.
module hadamard2d_block_transform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [hbt_pkg::DATA_W-1:0]   sample,
	input  logic                                cfg_wr_en,
	input  logic [hbt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hbt_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                result_valid,
	output logic signed [hbt_pkg::DATA_W-1:0]   coefficient,
	output logic                                last
);
	import hbt_pkg::*;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_STAGE,
		ST_DRAIN,
		ST_OUT,
		ST_FLUSH
	} state_t;

	state_t              state_q;
	logic [LOG_W-1:0]    log2_q;
	logic                inv_q;
	logic [CNT_W-1:0]    fill_q;
	logic [STAGE_W-1:0]  stage_q;
	logic [ADDR_W-2:0]   pair_q;
	logic                phase_q;
	logic [ADDR_W-1:0]   k_q;

	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   a_addr_s1;
	logic [ADDR_W-1:0]   b_addr_s1;
	logic                diff_vld_s2;
	logic [ADDR_W-1:0]   b_addr_s2;
	logic [DATA_W-1:0]   diff_s2;
	logic                out_vld_s1;
	logic                out_last_s1;

	logic                accept;
	logic [STAGE_W-1:0]  shamt;
	logic [CNT_W-1:0]    area;
	logic [ADDR_W-2:0]   last_pair;
	logic [STAGE_W-1:0]  last_stage;
	logic [ADDR_W-1:0]   addr_a;
	logic [ADDR_W-1:0]   addr_b;
	logic [ADDR_W-1:0]   raddr_a;
	logic                we;
	logic [ADDR_W-1:0]   waddr;
	logic [DATA_W-1:0]   wdata;
	logic [DATA_W-1:0]   dout_a;
	logic [DATA_W-1:0]   dout_b;
	logic [DATA_W-1:0]   bf_sum;
	logic [DATA_W-1:0]   bf_diff;
	logic [DATA_W-1:0]   bias;
	logic [DATA_W:0]     biased;
	logic [DATA_W:0]     quot;
	logic [DATA_W-1:0]   coef_next;

	function automatic logic [ADDR_W-1:0] pair_addr(input logic [ADDR_W-2:0] pair,
			input logic [STAGE_W-1:0] pos);
		logic [ADDR_W-1:0] p_ext;
		logic [ADDR_W-1:0] lo_mask;
		logic [ADDR_W-1:0] hi;
		p_ext   = {1'b0, pair};
		lo_mask = (ADDR_W'(1) << pos) - ADDR_W'(1);
		hi      = (p_ext >> pos) << (pos + STAGE_W'(1));
		return hi | (p_ext & lo_mask);
	endfunction

	assign busy       = (state_q != ST_LOAD);
	assign accept     = start && !busy;
	assign shamt      = {1'b0, log2_q} << 1;
	assign area       = CNT_W'(1) << shamt;
	assign last_pair  = (ADDR_W-1)'((area >> 1) - CNT_W'(1));
	assign last_stage = shamt - STAGE_W'(1);

	assign addr_a  = pair_addr(pair_q, stage_q);
	assign addr_b  = addr_a | (ADDR_W'(1) << stage_q);
	assign raddr_a = (state_q == ST_OUT) ? k_q : addr_a;

	assign bf_sum  = dout_a + dout_b;
	assign bf_diff = dout_a - dout_b;

	always_comb begin
		we    = 1'b0;
		waddr = fill_q[ADDR_W-1:0];
		wdata = sample;
		if (accept) begin
			we = 1'b1;
		end else if (rd_vld_s1) begin
			we    = 1'b1;
			waddr = a_addr_s1;
			wdata = bf_sum;
		end else if (diff_vld_s2) begin
			we    = 1'b1;
			waddr = b_addr_s2;
			wdata = diff_s2;
		end
	end

	// truncate toward zero: bias negative values by area - 1 before the shift
	assign bias      = (DATA_W'(1) << shamt) - DATA_W'(1);
	assign biased    = {dout_a[DATA_W-1], dout_a} + (dout_a[DATA_W-1] ? {1'b0, bias} : '0);
	assign quot      = DATA_W'(0) + ($signed(biased) >>> shamt);
	assign coef_next = inv_q ? quot[DATA_W-1:0] : dout_a;

	hbt_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr_a),
		.rdata (dout_a)
	);

	hbt_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_b),
		.rdata (dout_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			log2_q       <= LOG_W'(2);
			inv_q        <= 1'b0;
			fill_q       <= '0;
			stage_q      <= '0;
			pair_q       <= '0;
			phase_q      <= 1'b0;
			k_q          <= '0;
			rd_vld_s1    <= 1'b0;
			diff_vld_s2  <= 1'b0;
			out_vld_s1   <= 1'b0;
			out_last_s1  <= 1'b0;
			result_valid <= 1'b0;
			coefficient  <= '0;
			last         <= 1'b0;
		end else begin
			rd_vld_s1    <= 1'b0;
			diff_vld_s2  <= rd_vld_s1;
			out_vld_s1   <= 1'b0;
			out_last_s1  <= 1'b0;
			result_valid <= out_vld_s1;
			last         <= out_vld_s1 && out_last_s1;
			if (out_vld_s1) begin
				coefficient <= coef_next;
			end
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (fill_q + CNT_W'(1) == area) begin
							fill_q  <= '0;
							stage_q <= '0;
							pair_q  <= '0;
							phase_q <= 1'b0;
							k_q     <= '0;
							state_q <= (log2_q == '0) ? ST_OUT : ST_STAGE;
						end else begin
							fill_q <= fill_q + CNT_W'(1);
						end
					end
				end
				ST_STAGE: begin
					if (!phase_q) begin
						rd_vld_s1 <= 1'b1;
						phase_q   <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (pair_q == last_pair) begin
							pair_q  <= '0;
							state_q <= ST_DRAIN;
						end else begin
							pair_q <= pair_q + (ADDR_W-1)'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (stage_q == last_stage) begin
						stage_q <= '0;
						k_q     <= '0;
						state_q <= ST_OUT;
					end else begin
						stage_q <= stage_q + STAGE_W'(1);
						state_q <= ST_STAGE;
					end
				end
				ST_OUT: begin
					out_vld_s1 <= 1'b1;
					if ({1'b0, k_q} == area - CNT_W'(1)) begin
						out_last_s1 <= 1'b1;
						state_q     <= ST_FLUSH;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				ST_FLUSH: begin
					state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_BLOCK_SIZE_LOG2: begin
						log2_q <= cfg_data[LOG_W-1:0];
						fill_q <= '0;
					end
					CFG_INVERSE_MODE: begin
						inv_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STAGE && !phase_q) begin
			a_addr_s1 <= addr_a;
			b_addr_s1 <= addr_b;
		end
		if (rd_vld_s1) begin
			diff_s2   <= bf_diff;
			b_addr_s2 <= b_addr_s1;
		end
	end

	a_wr_one: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_vld_s1 && diff_vld_s2))
		else $error("sum and difference writes collide");

	a_no_load_wr: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 || diff_vld_s2) |-> busy)
		else $error("butterfly write while loading");

	a_last_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> result_valid)
		else $error("last without result strobe");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (fill_q < area))
		else $error("fill count beyond block area");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without transform in progress");

endmodule
